// ===== design/lifegen_pkg.sv =====
package lifegen_pkg;

    localparam int SIZE_LIMIT = 256;
    localparam int MIN_SIZE = 3;
    localparam int DEF_MAX_ROWS = 256;
    localparam int DEF_MAX_COLS = 256;
    localparam int WIN = 3;
    localparam int CNT_W = 4;
    localparam int POS_W = 8;
    localparam int CFG_W = 9;

    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] STAY_COUNT = 4'd2;

    localparam logic [8:0] ROWS_RESET = 9'd120;
    localparam logic [8:0] COLS_RESET = 9'd150;

    localparam logic CFG_GRID_ROWS = 1'b0;
    localparam logic CFG_GRID_COLS = 1'b1;

    typedef logic [WIN-1:0] col_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic cell_alive;
        logic frame_start;
    } in_beat_t;

    typedef struct packed {
        logic             next_alive;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             frame_done;
    } out_beat_t;

endpackage

// ===== design/lifegen_cell.sv =====
module lifegen_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               shift_en,
    input  lifegen_pkg::col_t  col_in,
    input  lifegen_pkg::cnt_t  cnt_in,
    output lifegen_pkg::col_t  col_out,
    output lifegen_pkg::cnt_t  cnt_out
);

    lifegen_pkg::col_t col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (shift_en) begin
            col_reg <= col_in;
        end
    end

    // running count over the window as it stands after this shift
    assign cnt_out = cnt_in
                   + lifegen_pkg::cnt_t'(col_in[0])
                   + lifegen_pkg::cnt_t'(col_in[1])
                   + lifegen_pkg::cnt_t'(col_in[2]);
    assign col_out = col_reg;

endmodule

// ===== design/lifegen_line_buf.sv =====
module lifegen_line_buf #(
    parameter int DEPTH = lifegen_pkg::SIZE_LIMIT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [1:0]               rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [1:0]               wr_data
);

    logic [1:0]       mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [1:0]       rd_data_reg;
    logic             rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_vld_reg <= vld_reg[rd_addr];
            end
        end
    end

    // never written entries read as dead
    assign rd_data = rd_vld_reg ? rd_data_reg : 2'b00;

endmodule

// ===== design/life_b3s23_generation_stream_top.sv =====
// channel | ports                     | beat
// --------+---------------------------+-------------------------------------
// input   | s_valid s_ready s_data    | cell_alive, frame_start
// result  | m_valid m_ready m_data    | next_alive, out_row, out_col, frame_done
// config  | cfg_we cfg_index cfg_wdata| grid_rows (0), grid_cols (1)
//
// one input beat per clock while no result stalls; each result passes the registered
// line buffer read stage and then the output register
// aresetn (synchronous) clears counters, window cells and line buffer valid bits
// at once; no clearing pass, the block accepts beats on the first cycle after reset
// a stalled result register holds one beat while the next cell waits in the
// read stage; s_ready drops only when both are full and m_ready is low
module life_b3s23_generation_stream_top #(
    parameter int MAX_ROWS = lifegen_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = lifegen_pkg::DEF_MAX_COLS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  lifegen_pkg::in_beat_t              s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output lifegen_pkg::out_beat_t             m_data,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [lifegen_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int ROW_CAP = (MAX_ROWS < lifegen_pkg::SIZE_LIMIT) ? MAX_ROWS
                                                                  : lifegen_pkg::SIZE_LIMIT;
    localparam int COL_CAP = (MAX_COLS < lifegen_pkg::SIZE_LIMIT) ? MAX_COLS
                                                                  : lifegen_pkg::SIZE_LIMIT;
    localparam int AW = $clog2(COL_CAP);
    localparam int PW = lifegen_pkg::POS_W;
    localparam int CW = lifegen_pkg::CFG_W;
    localparam int WIN = lifegen_pkg::WIN;

    logic [CW-1:0] grid_rows_reg;
    logic [CW-1:0] grid_cols_reg;
    logic [CW-1:0] rows_use;
    logic [CW-1:0] cols_use;
    logic [CW-1:0] rows_m1;
    logic [CW-1:0] cols_m1;

    logic [PW-1:0] row_count_reg;
    logic [PW-1:0] col_count_reg;
    logic [PW-1:0] row_count_next;
    logic [PW-1:0] col_count_next;
    logic [PW-1:0] r_raw;
    logic [PW-1:0] c_raw;
    logic [PW-1:0] r_in;
    logic [PW-1:0] c_in;

    logic accept;
    logic s1_adv;
    logic hit;

    logic          s1_valid_reg;
    logic          s1_cell_reg;
    logic [PW-1:0] s1_col_reg;
    logic          s1_emit_reg;
    logic          s1_inner_reg;
    logic          s1_done_reg;
    logic [PW-1:0] s1_orow_reg;
    logic [PW-1:0] s1_ocol_reg;
    logic          s1_hit_reg;
    logic [1:0]    s1_fwd_reg;

    logic [1:0] lb_rd_data;
    logic [1:0] old_lines;
    logic [1:0] wr_data;

    lifegen_pkg::col_t col_q [WIN+1];
    lifegen_pkg::cnt_t cnt_c [WIN+1];
    lifegen_pkg::cnt_t neigh;
    logic              center;
    logic              alive;

    logic                   m_valid_reg;
    lifegen_pkg::out_beat_t m_data_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= lifegen_pkg::ROWS_RESET;
            grid_cols_reg <= lifegen_pkg::COLS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                lifegen_pkg::CFG_GRID_ROWS: grid_rows_reg <= cfg_wdata;
                lifegen_pkg::CFG_GRID_COLS: grid_cols_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (grid_rows_reg < CW'(lifegen_pkg::MIN_SIZE)) begin
            rows_use = CW'(lifegen_pkg::MIN_SIZE);
        end else if (grid_rows_reg > CW'(ROW_CAP)) begin
            rows_use = CW'(ROW_CAP);
        end else begin
            rows_use = grid_rows_reg;
        end
        if (grid_cols_reg < CW'(lifegen_pkg::MIN_SIZE)) begin
            cols_use = CW'(lifegen_pkg::MIN_SIZE);
        end else if (grid_cols_reg > CW'(COL_CAP)) begin
            cols_use = CW'(COL_CAP);
        end else begin
            cols_use = grid_cols_reg;
        end
    end

    assign rows_m1 = rows_use - CW'(1);
    assign cols_m1 = cols_use - CW'(1);

    // position of the arriving cell
    assign r_raw = s_data.frame_start ? '0 : row_count_reg;
    assign c_raw = s_data.frame_start ? '0 : col_count_reg;
    assign r_in = ({1'b0, r_raw} >= rows_use) ? rows_m1[PW-1:0] : r_raw;
    assign c_in = ({1'b0, c_raw} >= cols_use) ? cols_m1[PW-1:0] : c_raw;

    always_comb begin
        if ({1'b0, c_in} >= cols_m1) begin
            col_count_next = '0;
            row_count_next = ({1'b0, r_in} >= rows_m1) ? '0 : r_in + PW'(1);
        end else begin
            col_count_next = c_in + PW'(1);
            row_count_next = r_in;
        end
    end

    assign s1_adv = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || s1_adv;
    assign accept = s_valid && s_ready;
    assign hit = s1_adv && (s1_col_reg == c_in);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_count_reg <= '0;
            col_count_reg <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                row_count_reg <= row_count_next;
                col_count_reg <= col_count_next;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cell_reg <= s_data.cell_alive;
            s1_col_reg <= c_in;
            s1_emit_reg <= (r_in != '0) && (c_in != '0);
            s1_inner_reg <= (r_in >= PW'(2)) && (c_in >= PW'(2));
            s1_done_reg <= ({1'b0, r_in} == rows_m1) && ({1'b0, c_in} == cols_m1);
            s1_orow_reg <= r_in - PW'(1);
            s1_ocol_reg <= c_in - PW'(1);
            s1_hit_reg <= hit;
            s1_fwd_reg <= wr_data;
        end
    end

    // bit 0 line above, bit 1 two lines above
    lifegen_line_buf #(
        .DEPTH(COL_CAP)
    ) u_line_buf (
        .aclk(aclk),
        .aresetn(aresetn),
        .rd_en(accept),
        .rd_addr(c_in[AW-1:0]),
        .rd_data(lb_rd_data),
        .wr_en(s1_adv),
        .wr_addr(s1_col_reg[AW-1:0]),
        .wr_data(wr_data)
    );

    assign old_lines = s1_hit_reg ? s1_fwd_reg : lb_rd_data;
    assign wr_data = {old_lines[0], s1_cell_reg};

    // window chain, newest column enters at the top end
    assign col_q[WIN] = {s1_cell_reg, old_lines[0], old_lines[1]};
    assign cnt_c[WIN] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < WIN; gi++) begin : g_win
            lifegen_cell u_cell (
                .aclk(aclk),
                .aresetn(aresetn),
                .shift_en(s1_adv),
                .col_in(col_q[gi+1]),
                .cnt_in(cnt_c[gi+1]),
                .col_out(col_q[gi]),
                .cnt_out(cnt_c[gi])
            );
        end
    endgenerate

    assign center = col_q[WIN-1][1];
    assign neigh = cnt_c[0] - lifegen_pkg::cnt_t'(center);
    assign alive = s1_inner_reg && ((neigh == lifegen_pkg::BIRTH_COUNT)
                   || (center && (neigh == lifegen_pkg::STAY_COUNT)));

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= s1_emit_reg;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_emit_reg) begin
            m_data_reg.next_alive <= alive;
            m_data_reg.out_row <= s1_orow_reg;
            m_data_reg.out_col <= s1_ocol_reg;
            m_data_reg.frame_done <= s1_done_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    a_border_dead: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.next_alive |-> (m_data.out_row != '0) && (m_data.out_col != '0))
        else $error("border cell reported alive");

    a_done_col: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.frame_done |-> ({1'b0, m_data.out_col} == cols_use - CW'(2)))
        else $error("frame end flagged off the last inner column");

    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> s1_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled with room in the pipeline");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.frame_start |=> (col_count_reg == PW'(1)) && (row_count_reg == '0))
        else $error("frame start did not restart the position");

endmodule
